### hdl/hmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_pkg: shared types and constants of the binary min-heap queue
// Word formats, status codes and the command and flag groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package hmq_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    localparam logic OP_INSERT  = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic                        operation;
        logic signed [KEY_WIDTH-1:0] key_in;
    } t_in_word;

    typedef struct packed {
        logic signed [KEY_WIDTH-1:0] key_out;
        logic [1:0]                  status;
        logic [CNT_W-1:0]            occupancy;
    } t_out_word;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_REFUSE_FULL,
        CMD_REFUSE_EMPTY,
        CMD_INS_INIT,
        CMD_UP_READ,
        CMD_UP_MOVE,
        CMD_UP_PLACE,
        CMD_EXT_INIT,
        CMD_EXT_ROOT_DONE,
        CMD_EXT_ROOT_NEXT,
        CMD_EXT_LOAD_LAST,
        CMD_DN_READ_LEFT,
        CMD_DN_READ_RIGHT,
        CMD_DN_MOVE_RD_LEFT,
        CMD_DN_MOVE_RIGHT,
        CMD_DN_MOVE_LEFT,
        CMD_DN_PLACE
    } t_dp_cmd;

    typedef struct packed {
        t_dp_cmd cmd;
    } t_dp_ctrl;

    typedef struct packed {
        logic op_extract;
        logic full;
        logic empty;
        logic pos_zero;
        logic parent_gt;
        logic left_out;
        logic right_in;
        logic key_gt_rd;
        logic key_gt_left;
        logic rd_lt_left;
    } t_dp_flags;

endpackage

### hdl/hmq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module hmq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/hmq_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_controller: sequencer of the heap queue
// Walks one insert or extract through its sift steps and issues one
// datapath command per cycle; drives busy and the result strobe.
// ----------------------------------------------------------------------------
module hmq_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hmq_pkg::t_dp_flags i_flags,
    output hmq_pkg::t_dp_ctrl o_ctrl,
    output logic              busy,
    output logic              o_valid
);
    import hmq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_UP_TEST,
        S_UP_CMP,
        S_EXT_ROOT,
        S_EXT_LAST,
        S_DN_TEST,
        S_DN_LEFT,
        S_DN_RIGHT
    } t_state;

    t_state  r_state, n_state;
    logic    r_busy, r_valid;
    logic    n_finish;
    t_dp_cmd n_cmd;

    always_comb begin
        n_state  = r_state;
        n_cmd    = CMD_NONE;
        n_finish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start && !r_busy) begin
                    n_cmd   = CMD_LOAD;
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_flags.op_extract) begin
                    if (i_flags.empty) begin
                        n_cmd    = CMD_REFUSE_EMPTY;
                        n_finish = 1'b1;
                    end else begin
                        n_cmd   = CMD_EXT_INIT;
                        n_state = S_EXT_ROOT;
                    end
                end else begin
                    if (i_flags.full) begin
                        n_cmd    = CMD_REFUSE_FULL;
                        n_finish = 1'b1;
                    end else begin
                        n_cmd   = CMD_INS_INIT;
                        n_state = S_UP_TEST;
                    end
                end
            end
            S_UP_TEST: begin
                if (i_flags.pos_zero) begin
                    n_cmd    = CMD_UP_PLACE;
                    n_finish = 1'b1;
                end else begin
                    n_cmd   = CMD_UP_READ;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (i_flags.parent_gt) begin
                    n_cmd   = CMD_UP_MOVE;
                    n_state = S_UP_TEST;
                end else begin
                    n_cmd    = CMD_UP_PLACE;
                    n_finish = 1'b1;
                end
            end
            S_EXT_ROOT: begin
                // The count is already decremented: zero means the last key left.
                if (i_flags.empty) begin
                    n_cmd    = CMD_EXT_ROOT_DONE;
                    n_finish = 1'b1;
                end else begin
                    n_cmd   = CMD_EXT_ROOT_NEXT;
                    n_state = S_EXT_LAST;
                end
            end
            S_EXT_LAST: begin
                n_cmd   = CMD_EXT_LOAD_LAST;
                n_state = S_DN_TEST;
            end
            S_DN_TEST: begin
                if (i_flags.left_out) begin
                    n_cmd    = CMD_DN_PLACE;
                    n_finish = 1'b1;
                end else begin
                    n_cmd   = CMD_DN_READ_LEFT;
                    n_state = S_DN_LEFT;
                end
            end
            S_DN_LEFT: begin
                if (i_flags.right_in) begin
                    n_cmd   = CMD_DN_READ_RIGHT;
                    n_state = S_DN_RIGHT;
                end else if (i_flags.key_gt_rd) begin
                    n_cmd   = CMD_DN_MOVE_RD_LEFT;
                    n_state = S_DN_TEST;
                end else begin
                    n_cmd    = CMD_DN_PLACE;
                    n_finish = 1'b1;
                end
            end
            S_DN_RIGHT: begin
                // The right child wins only when strictly smaller than the left.
                if (i_flags.rd_lt_left) begin
                    if (i_flags.key_gt_rd) begin
                        n_cmd   = CMD_DN_MOVE_RIGHT;
                        n_state = S_DN_TEST;
                    end else begin
                        n_cmd    = CMD_DN_PLACE;
                        n_finish = 1'b1;
                    end
                end else begin
                    if (i_flags.key_gt_left) begin
                        n_cmd   = CMD_DN_MOVE_LEFT;
                        n_state = S_DN_TEST;
                    end else begin
                        n_cmd    = CMD_DN_PLACE;
                        n_finish = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (n_finish) begin
            n_state = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_finish;
            if (n_cmd == CMD_LOAD) begin
                r_busy <= 1'b1;
            end else if (n_finish) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_ctrl.cmd = i_rst_n ? n_cmd : CMD_NONE;
    assign busy       = r_busy;
    assign o_valid    = r_valid;

endmodule

### hdl/hmq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_datapath: heap storage and sift datapath
// Holds the key store, the element count, the moving key and the current
// slot, and reports compare results to the controller.
// ----------------------------------------------------------------------------
module hmq_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hmq_pkg::t_in_word  i_in_word,
    input  hmq_pkg::t_dp_ctrl  i_ctrl,
    output hmq_pkg::t_dp_flags o_flags,
    output hmq_pkg::t_out_word o_out_word
);
    import hmq_pkg::*;

    logic                        r_op;
    logic signed [KEY_WIDTH-1:0] r_key;
    logic signed [KEY_WIDTH-1:0] r_left;
    logic signed [KEY_WIDTH-1:0] r_root;
    logic [ADDR_W-1:0]           r_pos;
    logic [CNT_W-1:0]            r_count;
    t_out_word                   r_out;

    logic signed [KEY_WIDTH-1:0] rd_key;
    logic signed [KEY_WIDTH-1:0] wr_data;
    logic                        wr_en;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic [CNT_W:0]              left_idx;
    logic [CNT_W:0]              right_idx;
    logic [CNT_W:0]              count_ext;
    logic [ADDR_W-1:0]           parent_idx;

    // The moving key is held aside and written once where it settles, so each
    // level costs one or two reads and at most one write.
    assign left_idx   = (CNT_W + 1)'({r_pos, 1'b1});
    assign right_idx  = left_idx + 1'b1;
    assign count_ext  = {1'b0, r_count};
    assign parent_idx = ADDR_W'((r_pos - 1'b1) >> 1);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_key;
        rd_addr = r_pos;
        case (i_ctrl.cmd)
            CMD_EXT_INIT:      rd_addr = '0;
            CMD_UP_READ:       rd_addr = parent_idx;
            CMD_EXT_ROOT_NEXT: rd_addr = r_count[ADDR_W-1:0];
            CMD_DN_READ_LEFT:  rd_addr = left_idx[ADDR_W-1:0];
            CMD_DN_READ_RIGHT: rd_addr = right_idx[ADDR_W-1:0];
            CMD_UP_PLACE,
            CMD_DN_PLACE: begin
                wr_en = 1'b1;
            end
            CMD_UP_MOVE,
            CMD_DN_MOVE_RD_LEFT,
            CMD_DN_MOVE_RIGHT: begin
                wr_en   = 1'b1;
                wr_data = rd_key;
            end
            CMD_DN_MOVE_LEFT: begin
                wr_en   = 1'b1;
                wr_data = r_left;
            end
            default: begin
            end
        endcase
    end

    hmq_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_key)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            case (i_ctrl.cmd)
                CMD_INS_INIT: r_count <= r_count + 1'b1;
                CMD_EXT_INIT: r_count <= r_count - 1'b1;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_LOAD: begin
                r_op  <= i_in_word.operation;
                r_key <= i_in_word.key_in;
            end
            CMD_REFUSE_FULL:     r_out <= '{key_out: '0, status: ST_FULL, occupancy: r_count};
            CMD_REFUSE_EMPTY:    r_out <= '{key_out: '0, status: ST_EMPTY, occupancy: r_count};
            CMD_INS_INIT:        r_pos <= r_count[ADDR_W-1:0];
            CMD_UP_MOVE:         r_pos <= parent_idx;
            CMD_UP_PLACE:        r_out <= '{key_out: '0, status: ST_OK, occupancy: r_count};
            CMD_EXT_ROOT_DONE:   r_out <= '{key_out: rd_key, status: ST_OK, occupancy: r_count};
            CMD_EXT_ROOT_NEXT:   r_root <= rd_key;
            CMD_EXT_LOAD_LAST: begin
                r_key <= rd_key;
                r_pos <= '0;
            end
            CMD_DN_READ_RIGHT:   r_left <= rd_key;
            CMD_DN_MOVE_RD_LEFT: r_pos <= left_idx[ADDR_W-1:0];
            CMD_DN_MOVE_LEFT:    r_pos <= left_idx[ADDR_W-1:0];
            CMD_DN_MOVE_RIGHT:   r_pos <= right_idx[ADDR_W-1:0];
            CMD_DN_PLACE:        r_out <= '{key_out: r_root, status: ST_OK, occupancy: r_count};
            default: begin
            end
        endcase
    end

    assign o_flags.op_extract  = (r_op == OP_EXTRACT);
    assign o_flags.full        = (r_count == CNT_W'(CAPACITY));
    assign o_flags.empty       = (r_count == '0);
    assign o_flags.pos_zero    = (r_pos == '0);
    assign o_flags.parent_gt   = (rd_key > r_key);
    assign o_flags.left_out    = (left_idx >= count_ext);
    assign o_flags.right_in    = (right_idx < count_ext);
    assign o_flags.key_gt_rd   = (r_key > rd_key);
    assign o_flags.key_gt_left = (r_key > r_left);
    assign o_flags.rd_lt_left  = (rd_key < r_left);

    assign o_out_word = r_out;

endmodule

### hdl/binary_min_heap_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_queue: priority queue of signed keys on a binary min-heap
// Each command word inserts a key or extracts the smallest key held.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; busy then stays
// high until the result word appears on o_out_word with o_valid high for one
// cycle, and the receiver must take it in that cycle. One command runs at a
// time, walking the heap one level at a time over the single read port of the
// key store. An insert into a full queue or an extract from an empty one is
// refused; an inserted key rises toward the root, and an extract that leaves
// keys behind sinks the last key down from the root until it settles. A new
// command may be accepted in the cycle the previous result is shown.
module binary_min_heap_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  hmq_pkg::t_in_word  i_in_word,
    output logic               busy,
    output logic               o_valid,
    output hmq_pkg::t_out_word o_out_word
);
    import hmq_pkg::*;

    t_dp_ctrl  ctrl;
    t_dp_flags flags;

    hmq_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_flags (flags),
        .o_ctrl  (ctrl),
        .busy    (busy),
        .o_valid (o_valid)
    );

    hmq_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_word  (i_in_word),
        .i_ctrl     (ctrl),
        .o_flags    (flags),
        .o_out_word (o_out_word)
    );

endmodule

### hdl/hmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hmq_checker: port-level checks of the heap queue
// Watches the command and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module hmq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic               o_valid,
    input hmq_pkg::t_out_word o_out_word
);
    import hmq_pkg::*;

    // A result word never follows directly on another one.
    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe high for two cycles in a row");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    // Busy drops exactly when the result word is shown.
    a_busy_ends_in_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result word");

    a_occupancy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_word.occupancy <= CNT_W'(CAPACITY)))
        else $error("occupancy beyond capacity");

    a_refused_zero_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out_word.status != ST_OK)) |-> (o_out_word.key_out == '0))
        else $error("refused command returned a nonzero key");

endmodule

bind binary_min_heap_queue hmq_checker u_hmq_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .o_valid    (o_valid),
    .o_out_word (o_out_word)
);
